### design/assert_macros.svh
// Assertion macros used by the queue RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define APQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define APQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/apq_pkg.sv
// Package: types, codes and defaults of the array priority queue.
package apq_pkg;

	localparam int DEPTH_DEF = 8;

	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic signed [31:0] value;
		logic [7:0]         prio;
	} entry_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] value;
		logic [7:0]         prio;
		logic [3:0]         occupancy;
	} result_t;

endpackage

### design/apq_mem.sv
// Entry memory: one write port, one read port, registered read data.
module apq_mem #(
	parameter int DEPTH = 8,
	parameter int AW    = 3
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  apq_pkg::entry_t wdata,
	input  logic [AW-1:0]   raddr,
	output apq_pkg::entry_t rdata
);
	import apq_pkg::*;

	entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### design/apq_ctrl.sv
// Queue sequencer: enqueue write, maximum scan and shift-down over the memory.
`include "assert_macros.svh"

module apq_ctrl #(
	parameter int DEPTH = 8,
	parameter int AW    = 3,
	parameter int CW    = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] new_value,
	input  logic [7:0]         new_priority,
	input  logic               res_free,
	output logic               res_load,
	output apq_pkg::result_t   res,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output apq_pkg::entry_t    mem_wdata,
	output logic [AW-1:0]      mem_raddr,
	input  apq_pkg::entry_t    mem_rdata
);
	import apq_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] issue_q;
	logic          pend_q;
	logic [AW-1:0] pidx_q;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;

	logic accept;
	logic issue_more;
	logic is_full;
	logic is_empty;
	logic walk_done;

	assign issue_more = (issue_q < count_q);
	assign is_full    = (count_q == CW'(DEPTH));
	assign is_empty   = (count_q == '0);
	assign walk_done  = !pend_q && !issue_more;
	assign in_stall   = !((state_q == S_IDLE) && res_free);
	assign accept     = in_valid && !in_stall;

	always_comb begin
		res_load      = 1'b0;
		res.status    = ST_DONE;
		res.value     = '0;
		res.prio      = '0;
		res.occupancy = 4'(count_q);
		mem_we        = 1'b0;
		mem_waddr     = '0;
		mem_wdata     = mem_rdata;
		mem_raddr     = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_load = 1'b1;
					if (cmd == CMD_ENQ) begin
						if (is_full) begin
							res.status = ST_FULL;
						end else begin
							mem_we          = 1'b1;
							mem_waddr       = count_q[AW-1:0];
							mem_wdata.value = new_value;
							mem_wdata.prio  = new_priority;
							res.occupancy   = 4'(count_q + 1'b1);
						end
					end else if (is_empty) begin
						res.status = ST_EMPTY;
					end else begin
						res_load = 1'b0;
					end
				end
			end
			S_SCAN: begin
				if (issue_more) begin
					mem_raddr = issue_q[AW-1:0];
				end
			end
			S_SHIFT: begin
				if (issue_more) begin
					mem_raddr = issue_q[AW-1:0];
				end
				if (pend_q) begin
					mem_we    = 1'b1;
					mem_waddr = pidx_q - 1'b1;
				end
				if (walk_done && res_free) begin
					res_load      = 1'b1;
					res.value     = best_q.value;
					res.prio      = best_q.prio;
					res.occupancy = 4'(count_q - 1'b1);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			pend_q     <= 1'b0;
			pidx_q     <= '0;
			best_idx_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (cmd == CMD_ENQ) begin
							if (!is_full) begin
								count_q <= count_q + 1'b1;
							end
						end else if (!is_empty) begin
							state_q <= S_SCAN;
							issue_q <= '0;
							pend_q  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
						pidx_q  <= issue_q[AW-1:0];
					end
					pend_q <= issue_more;
					if (pend_q && ((pidx_q == '0) || (mem_rdata.prio > best_q.prio))) begin
						best_idx_q <= pidx_q;
					end
					if (walk_done) begin
						state_q <= S_SHIFT;
						issue_q <= CW'(best_idx_q) + 1'b1;
						pend_q  <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (issue_more) begin
						issue_q <= issue_q + 1'b1;
						pidx_q  <= issue_q[AW-1:0];
					end
					pend_q <= issue_more;
					if (walk_done && res_free) begin
						count_q <= count_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// best entry payload, no reset needed
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && pend_q &&
				((pidx_q == '0) || (mem_rdata.prio > best_q.prio))) begin
			best_q <= mem_rdata;
		end
	end

	`APQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(DEPTH), "count above depth")
	`APQ_ASSERT_IMP(a_busy_nonempty, clk, arst_n, state_q != S_IDLE, count_q != '0, "busy while empty")
	`APQ_ASSERT_IMP(a_write_range, clk, arst_n, mem_we, CW'(mem_waddr) <= count_q, "write past fill")
	`APQ_ASSERT_NEXT(a_deq_start, clk, arst_n, accept && (cmd == CMD_DEQ) && !is_empty, state_q == S_SCAN, "dequeue did not start scan")

endmodule

### design/array_priority_queue_top.sv
// Top level of the array priority queue: memory, sequencer and result register.
//
// Input channel: in_valid/in_stall carry one item (cmd, new_value, new_priority).
// Output channel: out_valid/out_stall carry one result item (status, out_value,
// out_priority, occupancy) for every input item, in order.
// An enqueue, or an operation refused as full or empty, completes in the cycle
// it is accepted; its result is registered and valid in the cycle after.
// A successful dequeue walks the stored entries through the single memory
// read port: a scan finds the highest priority (earliest entry on a tie),
// then the entries after the removed one are shifted down one place.
// Its result is loaded once the shift is done and the output register is free.
// Only one item is in work at a time; in_stall is high while a dequeue runs.
// A finished result sits in the output register; a new item is accepted while
// it is taken in the same cycle, and held off while out_stall keeps it.
// Reset empties the queue and clears out_valid; stored entries are
// not cleared and need none.
module array_priority_queue_top #(
	parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic signed [31:0] new_value,
	input  logic [7:0]         new_priority,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic signed [31:0] out_value,
	output logic [7:0]         out_priority,
	output logic [3:0]         occupancy
);
	import apq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic          res_valid_q;
	result_t       res_q;
	logic          res_free;
	logic          res_load;
	result_t       res;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;
	logic [AW-1:0] mem_raddr;
	entry_t        mem_rdata;

	assign res_free = !res_valid_q || !out_stall;

	apq_mem #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	apq_ctrl #(
		.DEPTH(DEPTH),
		.AW   (AW),
		.CW   (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.new_value   (new_value),
		.new_priority(new_priority),
		.res_free    (res_free),
		.res_load    (res_load),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign out_valid    = res_valid_q;
	assign status       = res_q.status;
	assign out_value    = res_q.value;
	assign out_priority = res_q.prio;
	assign occupancy    = res_q.occupancy;

endmodule
